// ===== rtl/wpp_pkg.sv =====
// Package for the WAV PCM stream parser: item types, header codes and result helper.
package wpp_pkg;

    // Item on the byte channel
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } byte_item_t;

    // Item on the result channel
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic [2:0]         status;
        logic [1:0]         channel_count;
        logic [31:0]        sample_rate;
        logic [15:0]        bits_per_sample;
    } result_item_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_DONE
    } phase_t;

    // Result kinds
    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_RIFF    = 3'd1;
    localparam logic [2:0] ST_BAD_FMT_ID = 3'd2;
    localparam logic [2:0] ST_NOT_PCM    = 3'd3;
    localparam logic [2:0] ST_BAD_DATA   = 3'd4;
    localparam logic [2:0] ST_CHANNELS   = 3'd5;
    localparam logic [2:0] ST_EARLY_END  = 3'd6;
    localparam logic [2:0] ST_BIT_DEPTH  = 3'd7;

    // Chunk IDs, big-endian as read from the file
    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    localparam logic [31:0] PCM_FMT_SIZE = 32'd16;
    localparam logic [15:0] PCM_FMT_CODE = 16'd1;

    // Header byte positions where a field completes
    localparam logic [5:0] POS_RIFF     = 6'd3;
    localparam logic [5:0] POS_WAVE     = 6'd11;
    localparam logic [5:0] POS_FMT_ID   = 6'd15;
    localparam logic [5:0] POS_FMT_SIZE = 6'd19;
    localparam logic [5:0] POS_FMT_CODE = 6'd21;
    localparam logic [5:0] POS_CHANNELS = 6'd23;
    localparam logic [5:0] POS_RATE     = 6'd27;
    localparam logic [5:0] POS_DEPTH    = 6'd35;
    localparam logic [5:0] POS_DATA_ID  = 6'd39;
    localparam logic [5:0] POS_DATA_LEN = 6'd43;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // Assemble one result item from the held format fields
    function automatic result_item_t make_result(
        input logic [1:0]  kind,
        input logic [15:0] left,
        input logic [15:0] right,
        input logic [2:0]  status,
        input logic [15:0] channels,
        input logic [31:0] rate,
        input logic [15:0] depth
    );
        result_item_t r;
        r.kind            = kind;
        r.left_sample     = left;
        r.right_sample    = right;
        r.status          = status;
        r.channel_count   = (channels <= 16'd2) ? channels[1:0] : 2'd0;
        r.sample_rate     = rate;
        r.bits_per_sample = depth;
        return r;
    endfunction

endpackage

// ===== rtl/wav_pcm_stream_parser.sv =====
// WAV PCM stream parser: header checks, sample assembly and a small result queue.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+------------------------------
//  byte    | byte_valid   | byte_stall   | byte_item   (file byte, end mark)
//  result  | result_valid | result_stall | result_item (frame/header/status)
//
// One byte per cycle, while byte_stall is low, is taken into an input register
// and parsed from there straight into a four-entry result queue.
// A byte yields at most two results, so it is parsed only while the queue has
// two free entries; byte_stall rises when a two-result byte or a stalled
// result side leaves fewer than two free entries.
// Reset (rst_n low, async) returns to the header phase with all fields zero;
// a byte with end_of_file set does the same after it is parsed.
module wav_pcm_stream_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_stall,
    input  wpp_pkg::byte_item_t   byte_item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output wpp_pkg::result_item_t result_item
);
    import wpp_pkg::*;

    // Input register
    logic       in_valid_reg;
    byte_item_t in_item_reg;

    // Parser state
    phase_t      phase_reg,  phase_next;
    logic [5:0]  hp_reg,     hp_next;
    logic [31:0] fs_reg,     fs_next;
    logic [31:0] fcs_reg,    fcs_next;
    logic [15:0] fc_reg,     fc_next;
    logic [15:0] ch_reg,     ch_next;
    logic [31:0] rate_reg,   rate_next;
    logic [15:0] depth_reg,  depth_next;
    logic [31:0] dbl_reg,    dbl_next;
    logic [7:0]  lbh_reg,    lbh_next;
    logic        bis_reg,    bis_next;
    logic        ci_reg,     ci_next;
    logic [15:0] lh_reg,     lh_next;

    // Result queue
    result_item_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]         wr_ptr_reg;
    logic [FIFO_AW-1:0]         rd_ptr_reg;
    logic [FIFO_CW-1:0]         count_reg;

    logic        room;
    logic        advance;
    logic        pop;
    logic [1:0]  res_cnt;
    logic [1:0]  slot_kind   [2];
    logic [15:0] slot_left   [2];
    logic [15:0] slot_right  [2];
    logic [2:0]  slot_status [2];
    result_item_t res_item   [2];

    logic        is_id;
    logic        hdr_fail;
    logic [2:0]  hdr_code;
    logic        hdr_done;
    logic        is16;
    logic [15:0] sample;
    logic [31:0] len_mask;
    logic        eof_fail;

    // Handshakes
    assign room         = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign advance      = in_valid_reg && room;
    assign byte_stall   = in_valid_reg && !room;
    assign result_valid = (count_reg != '0);
    assign result_item  = fifo_mem[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            in_item_reg <= byte_item;
        end
    end

    // Parse one byte: next state and up to two results
    always_comb
    begin
        phase_next = phase_reg;
        hp_next    = hp_reg;
        fs_next    = fs_reg;
        fcs_next   = fcs_reg;
        fc_next    = fc_reg;
        ch_next    = ch_reg;
        rate_next  = rate_reg;
        depth_next = depth_reg;
        dbl_next   = dbl_reg;
        lbh_next   = lbh_reg;
        bis_next   = bis_reg;
        ci_next    = ci_reg;
        lh_next    = lh_reg;
        res_cnt    = 2'd0;
        for (int i = 0; i < 2; i++)
        begin
            slot_kind[i]   = KIND_FRAME;
            slot_left[i]   = '0;
            slot_right[i]  = '0;
            slot_status[i] = ST_OK;
        end
        is_id    = 1'b0;
        hdr_fail = 1'b0;
        hdr_code = ST_OK;
        hdr_done = 1'b0;
        is16     = (depth_reg == 16'd16);
        sample   = '0;
        len_mask = '1;
        eof_fail = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                // IDs shift in big-endian, numbers little-endian
                is_id = (hp_reg < 6'd4) || (hp_reg >= 6'd8 && hp_reg < 6'd16)
                     || (hp_reg >= 6'd36 && hp_reg < 6'd40);
                fs_next = is_id ? {fs_reg[23:0], in_item_reg.data_byte}
                                : {in_item_reg.data_byte, fs_reg[31:8]};
                hp_next = hp_reg + 6'd1;
                unique case (hp_reg)
                    POS_RIFF:
                    begin
                        if (fs_next != ID_RIFF)
                        begin
                            hdr_fail = 1'b1;
                            hdr_code = ST_NO_RIFF;
                        end
                    end
                    POS_WAVE:
                    begin
                        if (fs_next != ID_WAVE)
                        begin
                            hdr_fail = 1'b1;
                            hdr_code = ST_NO_RIFF;
                        end
                    end
                    POS_FMT_ID:
                    begin
                        if (fs_next != ID_FMT)
                        begin
                            hdr_fail = 1'b1;
                            hdr_code = ST_BAD_FMT_ID;
                        end
                    end
                    POS_FMT_SIZE: fcs_next = fs_next;
                    POS_FMT_CODE:
                    begin
                        fc_next = fs_next[31:16];
                        if (fcs_reg != PCM_FMT_SIZE || fs_next[31:16] != PCM_FMT_CODE)
                        begin
                            hdr_fail = 1'b1;
                            hdr_code = ST_NOT_PCM;
                        end
                    end
                    POS_CHANNELS: ch_next    = fs_next[31:16];
                    POS_RATE:     rate_next  = fs_next;
                    POS_DEPTH:    depth_next = fs_next[31:16];
                    POS_DATA_ID:
                    begin
                        if (fs_next != ID_DATA)
                        begin
                            hdr_fail = 1'b1;
                            hdr_code = ST_BAD_DATA;
                        end
                    end
                    POS_DATA_LEN:
                    begin
                        if (ch_reg != 16'd1 && ch_reg != 16'd2)
                        begin
                            hdr_fail = 1'b1;
                            hdr_code = ST_CHANNELS;
                        end
                        else if (depth_reg != 16'd8 && depth_reg != 16'd16)
                        begin
                            hdr_fail = 1'b1;
                            hdr_code = ST_BIT_DEPTH;
                        end
                        else
                        begin
                            hdr_done = 1'b1;
                        end
                    end
                    default: ;
                endcase

                if (hdr_fail)
                begin
                    hp_next        = hp_reg;
                    phase_next     = PH_DONE;
                    slot_kind[0]   = KIND_STATUS;
                    slot_status[0] = hdr_code;
                    res_cnt        = 2'd1;
                end
                else if (hdr_done)
                begin
                    // Round the data length down to whole frames
                    hp_next = hp_reg;
                    if (ch_reg == 16'd2 && is16)
                    begin
                        len_mask = ~32'd3;
                    end
                    else if (ch_reg == 16'd2 || is16)
                    begin
                        len_mask = ~32'd1;
                    end
                    dbl_next     = fs_next & len_mask;
                    slot_kind[0] = KIND_HEADER;
                    res_cnt      = 2'd1;
                    if (dbl_next == '0)
                    begin
                        phase_next   = PH_DONE;
                        slot_kind[1] = KIND_STATUS;
                        res_cnt      = 2'd2;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                // Sample assembly
                if (is16 && !bis_reg)
                begin
                    lbh_next = in_item_reg.data_byte;
                    bis_next = 1'b1;
                end
                else
                begin
                    sample   = is16 ? {in_item_reg.data_byte, lbh_reg}
                                    : {8'd0, in_item_reg.data_byte};
                    bis_next = 1'b0;
                    if (ch_reg == 16'd1)
                    begin
                        slot_kind[0] = KIND_FRAME;
                        slot_left[0] = sample;
                        res_cnt      = 2'd1;
                    end
                    else if (!ci_reg)
                    begin
                        lh_next = sample;
                        ci_next = 1'b1;
                    end
                    else
                    begin
                        ci_next       = 1'b0;
                        slot_kind[0]  = KIND_FRAME;
                        slot_left[0]  = lh_reg;
                        slot_right[0] = sample;
                        res_cnt       = 2'd1;
                    end
                end
                // Data byte countdown
                dbl_next = dbl_reg - 32'd1;
                if (dbl_next == '0)
                begin
                    phase_next                = PH_DONE;
                    slot_kind[res_cnt[0]]     = KIND_STATUS;
                    slot_status[res_cnt[0]]   = ST_OK;
                    res_cnt                   = res_cnt + 2'd1;
                end
            end
            default: ;
        endcase

        // End mark before the final status
        eof_fail = in_item_reg.end_of_file
                && (phase_next == PH_HEADER || phase_next == PH_DATA);
        if (eof_fail)
        begin
            slot_kind[res_cnt[0]]   = KIND_STATUS;
            slot_status[res_cnt[0]] = ST_EARLY_END;
            res_cnt                 = res_cnt + 2'd1;
        end

        for (int i = 0; i < 2; i++)
        begin
            res_item[i] = make_result(slot_kind[i], slot_left[i], slot_right[i],
                                      slot_status[i], ch_next, rate_next, depth_next);
        end
    end

    // Parser state registers; the end mark returns them to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hp_reg    <= '0;
            fs_reg    <= '0;
            fcs_reg   <= '0;
            fc_reg    <= '0;
            ch_reg    <= '0;
            rate_reg  <= '0;
            depth_reg <= '0;
            dbl_reg   <= '0;
            lbh_reg   <= '0;
            bis_reg   <= 1'b0;
            ci_reg    <= 1'b0;
            lh_reg    <= '0;
        end
        else if (advance)
        begin
            if (in_item_reg.end_of_file)
            begin
                phase_reg <= PH_HEADER;
                hp_reg    <= '0;
                fs_reg    <= '0;
                fcs_reg   <= '0;
                fc_reg    <= '0;
                ch_reg    <= '0;
                rate_reg  <= '0;
                depth_reg <= '0;
                dbl_reg   <= '0;
                lbh_reg   <= '0;
                bis_reg   <= 1'b0;
                ci_reg    <= 1'b0;
                lh_reg    <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                hp_reg    <= hp_next;
                fs_reg    <= fs_next;
                fcs_reg   <= fcs_next;
                fc_reg    <= fc_next;
                ch_reg    <= ch_next;
                rate_reg  <= rate_next;
                depth_reg <= depth_next;
                dbl_reg   <= dbl_next;
                lbh_reg   <= lbh_next;
                bis_reg   <= bis_next;
                ci_reg    <= ci_next;
                lh_reg    <= lh_next;
            end
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (res_cnt != 2'd0)
            begin
                fifo_mem[wr_ptr_reg] <= res_item[0];
            end
            if (res_cnt == 2'd2)
            begin
                fifo_mem[wr_ptr_reg + FIFO_AW'(1)] <= res_item[1];
            end
        end
    end

    // Result queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(res_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + (advance ? FIFO_CW'(res_cnt) : FIFO_CW'(0))
                       - (pop ? FIFO_CW'(1) : FIFO_CW'(0));
        end
    end

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A stalled result is never dropped from the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> count_reg >= $past(count_reg))
        else $error("stalled result lost");

    // The data phase only runs with an accepted format
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> (depth_reg == 16'd8 || depth_reg == 16'd16)
                              && (ch_reg == 16'd1 || ch_reg == 16'd2))
        else $error("data phase with bad format");

    // A held low byte exists only for 16-bit data
    assert property (@(posedge clk) disable iff (!rst_n)
        bis_reg |-> phase_reg == PH_DATA && depth_reg == 16'd16)
        else $error("low byte held outside 16-bit data");

endmodule
